>>> rtl/pta_pkg.sv
`default_nettype none

package pta_pkg;

   localparam int CSR_WIDTH       = 13;
   localparam int BYTE_WIDTH      = 8;
   localparam int GLYPH_WIDTH     = 7;
   localparam int LUMA_SUM_WIDTH  = 24;
   localparam int RAMP_SIZE       = 18;
   localparam int RAMP_IDX_WIDTH  = 5;
   localparam int OUTQ_DEPTH      = 4;
   localparam int OUTQ_AW         = 2;

   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;
   localparam int COLUMN_STEP_RESET  = 6;
   localparam int ROW_STEP_RESET     = 12;

   localparam logic [15:0] WEIGHT_FIRST  = 16'd19595;
   localparam logic [15:0] WEIGHT_SECOND = 16'd38470;
   localparam logic [15:0] WEIGHT_THIRD  = 16'd7471;

   typedef logic [GLYPH_WIDTH-1:0] glyph_type;

   localparam glyph_type NEWLINE = 7'h0A;

   localparam glyph_type RAMP_CHARS [RAMP_SIZE] = '{
      7'h4D, 7'h4E, 7'h44, 7'h38, 7'h4F, 7'h5A, 7'h24, 7'h37, 7'h49,
      7'h3F, 7'h2B, 7'h3D, 7'h7E, 7'h3A, 7'h2C, 7'h2E, 7'h2E, 7'h20
   };

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT,
      REG_COLUMN_STEP,
      REG_ROW_STEP
   } csr_reg_type;

   typedef struct packed {
      logic keep;
      logic newline;
      logic frame_end;
   } item_flags_type;

   typedef struct packed {
      glyph_type      glyph;
      item_flags_type flags;
   } queue_entry_type;

endpackage

`default_nettype wire

>>> rtl/pta_csr.sv
`default_nettype none

module pta_csr
   import pta_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [CSR_WIDTH-1:0]     csr_wdata,
   output logic [$clog2(MAX_DIM)-1:0] col_last,
   output logic [$clog2(MAX_DIM)-1:0] row_last,
   output logic [$clog2(MAX_DIM)-1:0] col_step_last,
   output logic [$clog2(MAX_DIM)-1:0] row_step_last
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int DW = (CW + 1 > CSR_WIDTH) ? CW + 1 : CSR_WIDTH;
   localparam logic [DW-1:0] MAX_EXT = DW'(MAX_DIM);
   localparam logic [CW-1:0] MAX_LAST = CW'(MAX_DIM - 1);

   localparam logic [CW-1:0] WIDTH_RST = (FRAME_WIDTH_RESET > MAX_DIM) ?
      MAX_LAST : CW'(FRAME_WIDTH_RESET - 1);
   localparam logic [CW-1:0] HEIGHT_RST = (FRAME_HEIGHT_RESET > MAX_DIM) ?
      MAX_LAST : CW'(FRAME_HEIGHT_RESET - 1);
   localparam logic [CW-1:0] COL_STEP_RST = (COLUMN_STEP_RESET > MAX_DIM) ?
      MAX_LAST : CW'(COLUMN_STEP_RESET - 1);
   localparam logic [CW-1:0] ROW_STEP_RST = (ROW_STEP_RESET > MAX_DIM) ?
      MAX_LAST : CW'(ROW_STEP_RESET - 1);

   // Each register is kept as its clamped value minus one, the last index it allows.
   function automatic logic [CW-1:0] last_of(input logic [CSR_WIDTH-1:0] v);
      logic [DW-1:0] ext;
      logic [DW-1:0] less;
      ext  = DW'(v);
      less = ext - DW'(1);
      if (v == '0) begin
         return '0;
      end else if (ext > MAX_EXT) begin
         return MAX_LAST;
      end else begin
         return less[CW-1:0];
      end
   endfunction

   logic [CW-1:0] col_last_ff, col_last_in;
   logic [CW-1:0] row_last_ff, row_last_in;
   logic [CW-1:0] col_step_ff, col_step_in;
   logic [CW-1:0] row_step_ff, row_step_in;
   logic [CW-1:0] wr_last;

   assign wr_last = last_of(csr_wdata);

   always_comb begin
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;
      col_step_in = col_step_ff;
      row_step_in = row_step_ff;
      if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_FRAME_WIDTH:  col_last_in = wr_last;
            REG_FRAME_HEIGHT: row_last_in = wr_last;
            REG_COLUMN_STEP:  col_step_in = wr_last;
            REG_ROW_STEP:     row_step_in = wr_last;
            default:          col_last_in = col_last_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff <= WIDTH_RST;
         row_last_ff <= HEIGHT_RST;
         col_step_ff <= COL_STEP_RST;
         row_step_ff <= ROW_STEP_RST;
      end else begin
         col_last_ff <= col_last_in;
         row_last_ff <= row_last_in;
         col_step_ff <= col_step_in;
         row_step_ff <= row_step_in;
      end
   end

   assign col_last      = col_last_ff;
   assign row_last      = row_last_ff;
   assign col_step_last = col_step_ff;
   assign row_step_last = row_step_ff;

endmodule

`default_nettype wire

>>> rtl/pta_scan.sv
`default_nettype none

module pta_scan
   import pta_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [$clog2(MAX_DIM)-1:0] col_last,
   input  logic [$clog2(MAX_DIM)-1:0] row_last,
   input  logic [$clog2(MAX_DIM)-1:0] col_step_last,
   input  logic [$clog2(MAX_DIM)-1:0] row_step_last,
   output logic                       item_valid,
   output item_flags_type             item_flags
);

   localparam int CW = $clog2(MAX_DIM);

   logic [CW-1:0] col_cnt_ff, col_cnt_in;
   logic [CW-1:0] row_cnt_ff, row_cnt_in;
   logic [CW-1:0] col_ph_ff, col_ph_in;
   logic [CW-1:0] row_ph_ff, row_ph_in;
   logic          row_had_ff, row_had_in;
   logic          row_kept;
   logic          keep;
   logic          last_col;
   logic          last_row;
   logic          newline;

   always_comb begin
      row_kept = (row_ph_ff == '0);
      keep     = row_kept && (col_ph_ff == '0);
      last_col = (col_cnt_ff >= col_last);
      last_row = (row_cnt_ff >= row_last);
      newline  = last_col && row_kept && (row_had_ff || keep);

      item_flags.keep      = keep;
      item_flags.newline   = newline;
      item_flags.frame_end = last_col && last_row;
      item_valid           = accept && (keep || newline);

      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      col_ph_in  = col_ph_ff;
      row_ph_in  = row_ph_ff;
      row_had_in = row_had_ff;

      if (accept) begin
         if (last_col) begin
            col_cnt_in = '0;
            col_ph_in  = '0;
            row_had_in = 1'b0;
            if (last_row) begin
               row_cnt_in = '0;
               row_ph_in  = '0;
            end else begin
               row_cnt_in = row_cnt_ff + CW'(1);
               row_ph_in  = (row_ph_ff >= row_step_last) ? '0 : row_ph_ff + CW'(1);
            end
         end else begin
            col_cnt_in = col_cnt_ff + CW'(1);
            col_ph_in  = (col_ph_ff >= col_step_last) ? '0 : col_ph_ff + CW'(1);
            if (keep) begin
               row_had_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         col_ph_ff  <= '0;
         row_ph_ff  <= '0;
         row_had_ff <= 1'b0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         col_ph_ff  <= col_ph_in;
         row_ph_ff  <= row_ph_in;
         row_had_ff <= row_had_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pta_luma.sv
`default_nettype none

module pta_luma
   import pta_pkg::*;
#(
   parameter int RAMP_LAST = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  item_flags_type        item_flags,
   input  logic [BYTE_WIDTH-1:0] first_byte,
   input  logic [BYTE_WIDTH-1:0] second_byte,
   input  logic [BYTE_WIDTH-1:0] third_byte,
   output logic                  wr_valid,
   output queue_entry_type       wr_entry
);

   localparam int RW = $clog2(RAMP_LAST + 1);
   localparam int XW = BYTE_WIDTH + RW;
   localparam int QW_RAW = RW + 1;
   localparam int QW = (QW_RAW > RAMP_IDX_WIDTH) ? QW_RAW : RAMP_IDX_WIDTH;
   localparam logic [QW-1:0] IDX_MAX = QW'(RAMP_SIZE - 1);

   logic                  a_valid_ff, a_valid_in;
   item_flags_type        a_flags_ff;
   logic [BYTE_WIDTH-1:0] a_first_ff, a_second_ff, a_third_ff;

   logic                  b_valid_ff, b_valid_in;
   item_flags_type        b_flags_ff;
   logic [BYTE_WIDTH-1:0] lum_ff, lum_in;

   logic [LUMA_SUM_WIDTH-1:0] lum_sum;
   logic [XW-1:0]             scaled;
   logic [XW:0]               div_sum;
   logic [QW_RAW-1:0]         quot;
   logic [QW-1:0]             quot_ext;
   logic [RAMP_IDX_WIDTH-1:0] ramp_idx;

   assign a_valid_in = item_valid;
   assign b_valid_in = a_valid_ff;

   assign lum_sum = LUMA_SUM_WIDTH'(WEIGHT_FIRST)  * LUMA_SUM_WIDTH'(a_first_ff)
                  + LUMA_SUM_WIDTH'(WEIGHT_SECOND) * LUMA_SUM_WIDTH'(a_second_ff)
                  + LUMA_SUM_WIDTH'(WEIGHT_THIRD)  * LUMA_SUM_WIDTH'(a_third_ff);
   assign lum_in = lum_sum[LUMA_SUM_WIDTH-1:LUMA_SUM_WIDTH-BYTE_WIDTH];

   // Division by 255 as (x + x/256 + 1) / 256, exact over the range of x used here.
   assign scaled   = XW'(lum_ff) * XW'(RAMP_LAST);
   assign div_sum  = (XW+1)'(scaled) + (XW+1)'(scaled >> 8) + (XW+1)'(1);
   assign quot     = div_sum[XW:8];
   assign quot_ext = QW'(quot);
   assign ramp_idx = (quot_ext > IDX_MAX) ? IDX_MAX[RAMP_IDX_WIDTH-1:0]
                                          : quot_ext[RAMP_IDX_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_flags_ff  <= item_flags;
      a_first_ff  <= first_byte;
      a_second_ff <= second_byte;
      a_third_ff  <= third_byte;
      b_flags_ff  <= a_flags_ff;
      lum_ff      <= lum_in;
   end

   assign wr_valid       = b_valid_ff;
   assign wr_entry.glyph = RAMP_CHARS[ramp_idx];
   assign wr_entry.flags = b_flags_ff;

endmodule

`default_nettype wire

>>> rtl/pta_outq.sv
`default_nettype none

module pta_outq
   import pta_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            claim,
   input  logic            wr_valid,
   input  queue_entry_type wr_entry,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output glyph_type       rsp_glyph,
   output logic            rsp_run_end,
   output logic            rsp_frame_end,
   output logic            full
);

   queue_entry_type       mem_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0]    wptr_ff, wptr_in;
   logic [OUTQ_AW-1:0]    rptr_ff, rptr_in;
   logic [OUTQ_AW:0]      fill_ff, fill_in;
   logic [OUTQ_AW:0]      credit_ff, credit_in;
   logic                  sub_ff, sub_in;
   queue_entry_type       head;
   logic                  two_words;
   logic                  final_word;
   logic                  take;
   logic                  pop;

   // The credit counts pixels with results from acceptance until their last word leaves,
   // so the queue can never overflow while the pipe ahead of it keeps moving.
   always_comb begin
      head       = mem_ff[rptr_ff];
      two_words  = head.flags.keep && head.flags.newline;
      final_word = !(two_words && !sub_ff);
      take       = rsp_valid && !rsp_stall;
      pop        = take && final_word;

      wptr_in   = wr_valid ? wptr_ff + OUTQ_AW'(1) : wptr_ff;
      rptr_in   = pop ? rptr_ff + OUTQ_AW'(1) : rptr_ff;
      fill_in   = fill_ff + (OUTQ_AW+1)'(wr_valid) - (OUTQ_AW+1)'(pop);
      credit_in = credit_ff + (OUTQ_AW+1)'(claim) - (OUTQ_AW+1)'(pop);

      sub_in = sub_ff;
      if (pop) begin
         sub_in = 1'b0;
      end else if (take) begin
         sub_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff   <= '0;
         rptr_ff   <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
         sub_ff    <= 1'b0;
      end else begin
         wptr_ff   <= wptr_in;
         rptr_ff   <= rptr_in;
         fill_ff   <= fill_in;
         credit_ff <= credit_in;
         sub_ff    <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         mem_ff[wptr_ff] <= wr_entry;
      end
   end

   assign rsp_valid     = (fill_ff != '0);
   assign rsp_glyph     = (head.flags.keep && !sub_ff) ? head.glyph : NEWLINE;
   assign rsp_run_end   = final_word;
   assign rsp_frame_end = head.flags.frame_end;
   assign full          = (credit_ff == (OUTQ_AW+1)'(OUTQ_DEPTH));

endmodule

`default_nettype wire

>>> rtl/pixel_to_ascii_decimator.sv
// Turns a raster stream of three-byte pixels into ASCII art. One pixel word is accepted
// per clock while req_stall is low; a decimated pixel leaves as one ramp character, and
// the pixel that closes a kept row adds a newline word after it. The output queue holds
// four pixels' worth of results, and req_stall rises only when four pixels with pending
// results are in flight. With rsp_stall low the block takes one pixel per cycle as long
// as no more than one result word per cycle has to leave; the extra newline words of
// closely spaced row ends can cost input cycles once the queue's single spare slot is
// used. Configuration writes take effect on the first pixel accepted after the write; no
// clearing pass follows reset.
`default_nettype none

module pixel_to_ascii_decimator
   import pta_pkg::*;
#(
   parameter int MAX_DIM   = 4096,
   parameter int RAMP_LAST = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_WIDTH-1:0] req_first_byte,
   input  logic [BYTE_WIDTH-1:0] req_second_byte,
   input  logic [BYTE_WIDTH-1:0] req_third_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [GLYPH_WIDTH-1:0] rsp_glyph,
   output logic                  rsp_run_end,
   output logic                  rsp_frame_end,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [CSR_WIDTH-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_DIM);

   logic [CW-1:0]   col_last;
   logic [CW-1:0]   row_last;
   logic [CW-1:0]   col_step_last;
   logic [CW-1:0]   row_step_last;
   logic            accept;
   logic            item_valid;
   item_flags_type  item_flags;
   logic            wr_valid;
   queue_entry_type wr_entry;
   logic            full;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   pta_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .col_last      (col_last),
      .row_last      (row_last),
      .col_step_last (col_step_last),
      .row_step_last (row_step_last)
   );

   pta_scan #(
      .MAX_DIM (MAX_DIM)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .col_last      (col_last),
      .row_last      (row_last),
      .col_step_last (col_step_last),
      .row_step_last (row_step_last),
      .item_valid    (item_valid),
      .item_flags    (item_flags)
   );

   pta_luma #(
      .RAMP_LAST (RAMP_LAST)
   ) u_luma (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_flags  (item_flags),
      .first_byte  (req_first_byte),
      .second_byte (req_second_byte),
      .third_byte  (req_third_byte),
      .wr_valid    (wr_valid),
      .wr_entry    (wr_entry)
   );

   pta_outq u_outq (
      .clock         (clock),
      .reset         (reset),
      .claim         (item_valid),
      .wr_valid      (wr_valid),
      .wr_entry      (wr_entry),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_glyph     (rsp_glyph),
      .rsp_run_end   (rsp_run_end),
      .rsp_frame_end (rsp_frame_end),
      .full          (full)
   );

endmodule

`default_nettype wire

>>> rtl/pta_checker.sv
`default_nettype none

module pta_checker
   import pta_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_stall,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [GLYPH_WIDTH-1:0] rsp_glyph,
   input  logic                   rsp_run_end,
   input  logic                   rsp_frame_end
);

   // A stalled result word stays on the port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_glyph) &&
         $stable(rsp_run_end) && $stable(rsp_frame_end))
      else $error("stalled result word changed");

   // A newline always closes the run of its pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_glyph == NEWLINE) |-> rsp_run_end)
      else $error("newline word without run end");

   // A word that does not end its run is a glyph followed at once by its newline.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_end |=>
         rsp_valid && (rsp_glyph == NEWLINE) && rsp_run_end)
      else $error("glyph word not followed by its newline");

   // Right after reset nothing is offered and the input is open.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid && !req_stall)
      else $error("block not empty right after reset");

endmodule

bind pixel_to_ascii_decimator pta_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_glyph     (rsp_glyph),
   .rsp_run_end   (rsp_run_end),
   .rsp_frame_end (rsp_frame_end)
);

`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none

module tb_top;
   import pta_pkg::*;

   localparam int DIM_LIMIT    = 4096;
   localparam int RAMP_TOP     = 16;
   localparam int RAMP_LENGTH  = 18;
   localparam int LONG_HOLD    = 80;
   localparam int SETTLE_WAIT  = 8;
   localparam int DRAIN_LIMIT  = 20000;
   localparam logic [GLYPH_WIDTH-1:0] LINE_FEED = 7'd10;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] first_byte;
      logic [BYTE_WIDTH-1:0] second_byte;
      logic [BYTE_WIDTH-1:0] third_byte;
   } pixel_type;

   typedef struct packed {
      logic [GLYPH_WIDTH-1:0] glyph;
      logic                   run_end;
      logic                   frame_end;
   } glyph_word_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_WIDTH-1:0]  req_first_byte = '0;
   logic [BYTE_WIDTH-1:0]  req_second_byte = '0;
   logic [BYTE_WIDTH-1:0]  req_third_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [GLYPH_WIDTH-1:0] rsp_glyph;
   logic                   rsp_run_end;
   logic                   rsp_frame_end;
   logic                   csr_write = 1'b0;
   logic [1:0]             csr_index = '0;
   logic [CSR_WIDTH-1:0]   csr_wdata = '0;

   string luma_ramp = "MND8OZ$7I?+=~:,.. ";

   logic [CSR_WIDTH-1:0] cfg_width;
   logic [CSR_WIDTH-1:0] cfg_height;
   logic [CSR_WIDTH-1:0] cfg_col_step;
   logic [CSR_WIDTH-1:0] cfg_row_step;
   logic [11:0]          col_count;
   logic [11:0]          row_count;
   logic [11:0]          col_phase;
   logic [11:0]          row_phase;
   logic                 row_had_glyph;

   glyph_word_type expected_glyphs[$];
   int             mismatch_count = 0;
   int             sender_idle_pct = 0;
   int             receiver_stall_pct = 0;
   int             holds_requested = 0;
   int             holds_served = 0;
   int             hold_left = 0;

   pixel_to_ascii_decimator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_first_byte  (req_first_byte),
      .req_second_byte (req_second_byte),
      .req_third_byte  (req_third_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_glyph       (rsp_glyph),
      .rsp_run_end     (rsp_run_end),
      .rsp_frame_end   (rsp_frame_end),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 400000);
      $display("pixel_to_ascii_decimator verification failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic int effective_dim(input logic [CSR_WIDTH-1:0] value);
      if (value == 0) begin
         return 1;
      end
      if (value > DIM_LIMIT) begin
         return DIM_LIMIT;
      end
      return int'(value);
   endfunction

   function automatic void clear_raster();
      cfg_width     = CSR_WIDTH'(FRAME_WIDTH_RESET);
      cfg_height    = CSR_WIDTH'(FRAME_HEIGHT_RESET);
      cfg_col_step  = CSR_WIDTH'(COLUMN_STEP_RESET);
      cfg_row_step  = CSR_WIDTH'(ROW_STEP_RESET);
      col_count     = '0;
      row_count     = '0;
      col_phase     = '0;
      row_phase     = '0;
      row_had_glyph = 1'b0;
   endfunction

   // Works out the words one accepted pixel causes and moves the raster position on.
   function automatic void advance_raster(input pixel_type px);
      int             w;
      int             h;
      int             cs;
      int             rs;
      int             luma;
      int             ramp_idx;
      logic           row_kept;
      logic           keep;
      logic           last_col;
      logic           last_row;
      glyph_word_type word;
      w        = effective_dim(cfg_width);
      h        = effective_dim(cfg_height);
      cs       = effective_dim(cfg_col_step);
      rs       = effective_dim(cfg_row_step);
      row_kept = (row_phase == 0);
      keep     = row_kept && (col_phase == 0);
      last_col = int'(col_count) >= w - 1;
      last_row = int'(row_count) >= h - 1;
      if (keep) begin
         luma = (19595 * int'(px.first_byte) + 38470 * int'(px.second_byte)
                 + 7471 * int'(px.third_byte)) >>> 16;
         ramp_idx = luma * RAMP_TOP / 255;
         if (ramp_idx > RAMP_LENGTH - 1) begin
            ramp_idx = RAMP_LENGTH - 1;
         end
         word.glyph     = GLYPH_WIDTH'(luma_ramp[ramp_idx]);
         word.run_end   = !last_col;
         word.frame_end = last_col && last_row;
         expected_glyphs.push_back(word);
      end
      if (last_col && row_kept && (row_had_glyph || keep)) begin
         word.glyph     = LINE_FEED;
         word.run_end   = 1'b1;
         word.frame_end = last_row;
         expected_glyphs.push_back(word);
      end
      if (last_col) begin
         col_count     = '0;
         col_phase     = '0;
         row_had_glyph = 1'b0;
         if (last_row) begin
            row_count = '0;
            row_phase = '0;
         end else begin
            row_count = row_count + 1'b1;
            row_phase = (int'(row_phase) >= rs - 1) ? '0 : row_phase + 1'b1;
         end
      end else begin
         col_count = col_count + 1'b1;
         col_phase = (int'(col_phase) >= cs - 1) ? '0 : col_phase + 1'b1;
         if (keep) begin
            row_had_glyph = 1'b1;
         end
      end
   endfunction

   always @(posedge clock) begin : result_check
      glyph_word_type got;
      glyph_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.glyph     = rsp_glyph;
         got.run_end   = rsp_run_end;
         got.frame_end = rsp_frame_end;
         if (expected_glyphs.size() == 0) begin
            report_mismatch($sformatf("unexpected word glyph=%h run_end=%b frame_end=%b",
                                      got.glyph, got.run_end, got.frame_end));
         end else begin
            want = expected_glyphs.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf("glyph %h/%h run_end %b/%b frame_end %b/%b (got/want)",
                                         got.glyph, want.glyph, got.run_end, want.run_end,
                                         got.frame_end, want.frame_end));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (holds_served != holds_requested) begin
         holds_served <= holds_requested;
         hold_left    <= LONG_HOLD;
         rsp_stall    <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct <= receiver_pct;
   endtask

   task automatic send_pixel(input pixel_type px);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_first_byte  <= px.first_byte;
      req_second_byte <= px.second_byte;
      req_third_byte  <= px.third_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_raster(px);
   endtask

   task automatic send_rgb(input int first, input int second, input int third);
      pixel_type px;
      px.first_byte  = BYTE_WIDTH'(first);
      px.second_byte = BYTE_WIDTH'(second);
      px.third_byte  = BYTE_WIDTH'(third);
      send_pixel(px);
   endtask

   function automatic pixel_type random_pixel();
      pixel_type px;
      case ($urandom_range(3))
         0: begin
            px.first_byte  = $urandom_range(1) ? 8'hFF : 8'h00;
            px.second_byte = $urandom_range(1) ? 8'hFF : 8'h00;
            px.third_byte  = $urandom_range(1) ? 8'hFF : 8'h00;
         end
         1: begin
            px.first_byte  = BYTE_WIDTH'($urandom_range(255));
            px.second_byte = px.first_byte;
            px.third_byte  = px.first_byte;
         end
         default: begin
            px.first_byte  = BYTE_WIDTH'($urandom_range(255));
            px.second_byte = BYTE_WIDTH'($urandom_range(255));
            px.third_byte  = BYTE_WIDTH'($urandom_range(255));
         end
      endcase
      return px;
   endfunction

   function automatic logic [CSR_WIDTH-1:0] random_dim(input int typical_max);
      int pick;
      pick = $urandom_range(99);
      if (pick < 6) begin
         return '0;
      end else if (pick < 10) begin
         return CSR_WIDTH'(DIM_LIMIT);
      end else if (pick < 13) begin
         return '1;
      end else if (pick < 16) begin
         return CSR_WIDTH'($urandom_range(8191));
      end
      return CSR_WIDTH'($urandom_range(1, typical_max));
   endfunction

   // The block may still hold a pixel that causes no word, so a few more cycles pass.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_glyphs.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_WIDTH-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_FRAME_WIDTH:  cfg_width    = value;
         REG_FRAME_HEIGHT: cfg_height   = value;
         REG_COLUMN_STEP:  cfg_col_step = value;
         REG_ROW_STEP:     cfg_row_step = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CSR_WIDTH-1:0] width,
                            input logic [CSR_WIDTH-1:0] height,
                            input logic [CSR_WIDTH-1:0] col_step,
                            input logic [CSR_WIDTH-1:0] row_step);
      write_reg(REG_FRAME_WIDTH, width);
      write_reg(REG_FRAME_HEIGHT, height);
      write_reg(REG_COLUMN_STEP, col_step);
      write_reg(REG_ROW_STEP, row_step);
      csr_write <= 1'b0;
   endtask

   task automatic test_default_setting();
      set_idling(0, 0);
      send_rgb(0, 0, 0);
      send_rgb(255, 255, 255);
      send_rgb(255, 0, 0);
      send_rgb(0, 255, 0);
      send_rgb(0, 0, 255);
      send_rgb(128, 128, 128);
      send_rgb(255, 255, 255);
   endtask

   // The shrink below lands mid-row, so the next pixel closes the row.
   task automatic test_every_pixel_kept();
      settle();
      configure(3, 2, 1, 1);
      repeat (6) send_pixel(random_pixel());
   endtask

   task automatic test_zero_and_oversized();
      settle();
      configure(0, 0, 0, 0);
      send_rgb(255, 255, 255);
      send_rgb(0, 0, 0);
      settle();
      configure('1, CSR_WIDTH'(DIM_LIMIT), '1, CSR_WIDTH'(DIM_LIMIT));
      send_rgb(90, 200, 30);
      send_rgb(10, 20, 250);
   endtask

   task automatic test_step_beyond_frame();
      settle();
      configure(4, 2, 9, 5);
      repeat (6) send_pixel(random_pixel());
   endtask

   task automatic test_random_streams();
      int sender_pct[4]   = '{0, 79, 0, 8};
      int receiver_pct[4] = '{0, 0, 79, 8};
      for (int p = 0; p < 4; p++) begin
         settle();
         set_idling(sender_pct[p], receiver_pct[p]);
         repeat (5) begin
            settle();
            configure(random_dim(12), random_dim(6), random_dim(5), random_dim(5));
            repeat ($urandom_range(25, 55)) send_pixel(random_pixel());
         end
      end
   endtask

   // The receiver holds off long enough for the output queue to fill and stall the input.
   task automatic test_input_backpressure();
      settle();
      set_idling(0, 0);
      configure(4, 3, 1, 1);
      holds_requested <= holds_requested + 1;
      repeat (30) send_pixel(random_pixel());
   endtask

   task automatic finish_run();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_glyphs.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_glyphs.size() != 0) begin
         report_mismatch($sformatf("%0d expected words never arrived", expected_glyphs.size()));
      end
      repeat (2 * SETTLE_WAIT) @(posedge clock);
   endtask

   initial begin
      clear_raster();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_default_setting();
      test_every_pixel_kept();
      test_zero_and_oversized();
      test_step_beyond_frame();
      test_random_streams();
      test_input_backpressure();
      finish_run();
      if (mismatch_count == 0) begin
         $display("pixel_to_ascii_decimator verification clean");
      end else begin
         $display("pixel_to_ascii_decimator verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
